@@ hw/rtl/multi_voice_sample_mixer_macros.svh @@
// Assertion helpers for the mixer.
`ifndef MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH
`define MULTI_VOICE_SAMPLE_MIXER_MACROS_SVH

// Clocked check, muted while in reset.
`define MVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MVM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hw/rtl/mvm_pkg.sv @@
package mvm_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_START = 2'd1,
    OP_FRAME = 2'd2,
    OP_TIME  = 2'd3
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [15:0] address;
    logic [7:0]  sample_byte;
    logic [7:0]  sound_id;
    logic [15:0] length;
    logic        exclusive;
    logic [17:0] step;
    logic [7:0]  volume;
    logic [7:0]  separation;
  } cmd_t;

  localparam logic [15:0] HANDLE_FIRST = 16'd100;
  localparam logic [7:0]  GAIN_MAX     = 8'd127;
  localparam logic [8:0]  SEP_SPAN     = 9'd257;
  // floor(65536/127); one correction step follows
  localparam logic [9:0]  RECIP_127    = 10'd516;
  localparam logic [16:0] DIV_127      = 17'd127;
  localparam logic [15:0] SAT_MAX      = 16'h7fff;
  localparam logic [15:0] SAT_MIN      = 16'h8000;

endpackage

@@ hw/rtl/mvm_in_if.sv @@
interface mvm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] address;
  logic [7:0]  sample_byte;
  logic [7:0]  sound_id;
  logic [15:0] length;
  logic        exclusive;
  logic [17:0] step;
  logic [7:0]  volume;
  logic [7:0]  separation;

  modport source (output valid, operation, address, sample_byte, sound_id, length, exclusive,
                  step, volume, separation, input ready);
  modport sink (input valid, operation, address, sample_byte, sound_id, length, exclusive,
                step, volume, separation, output ready);
endinterface

@@ hw/rtl/mvm_out_if.sv @@
interface mvm_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [15:0]        handle;
  logic [2:0]         voice;
  logic               status;
  logic               all_idle;

  modport source (output valid, left_sample, right_sample, handle, voice, status, all_idle,
                  input ready);
  modport sink (input valid, left_sample, right_sample, handle, voice, status, all_idle,
                output ready);
endinterface

@@ hw/rtl/mvm_ram.sv @@
module mvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mvm_front.sv @@
module mvm_front import mvm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  mvm_in_if.sink in_i,
  output cmd_t  cmd_o,
  output logic  cmd_valid_o,
  input  logic  cmd_pop_i
);

  cmd_t       q_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.op          = op_e'(in_i.operation);
    cmd_in.address     = in_i.address;
    cmd_in.sample_byte = in_i.sample_byte;
    cmd_in.sound_id    = in_i.sound_id;
    cmd_in.length      = in_i.length;
    cmd_in.exclusive   = in_i.exclusive;
    cmd_in.step        = in_i.step;
    cmd_in.volume      = in_i.volume;
    cmd_in.separation  = in_i.separation;
  end

  assign in_i.ready  = (cnt_q != 2'd2);
  assign push        = in_i.valid && in_i.ready;
  assign pop         = cmd_pop_i && (cnt_q != 2'd0);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (pop) rd_q <= ~rd_q;
      if (push && !pop) cnt_q <= cnt_q + 2'd1;
      else if (pop && !push) cnt_q <= cnt_q - 2'd1;
    end
  end

endmodule

@@ hw/rtl/mvm_back.sv @@
module mvm_back import mvm_pkg::*; #(
  parameter int VOICES = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  logic      cmd_valid_i,
  output logic      cmd_pop_o,
  mvm_out_if.source out_o
);

  localparam int AW   = $clog2(SAMPLE_MEM_DEPTH);
  localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ACCW = VW + 18;
  localparam logic [VW-1:0] LAST_V  = VW'(VOICES - 1);
  localparam logic [AW:0]   DEPTH_W = (AW+1)'(SAMPLE_MEM_DEPTH);
  localparam logic [16:0]   DEPTH_A = 17'(SAMPLE_MEM_DEPTH > 65536 ? 65536 : SAMPLE_MEM_DEPTH);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b0000_0000_0001,
    S_RED    = 12'b0000_0000_0010,
    S_MUL1   = 12'b0000_0000_0100,
    S_MUL2   = 12'b0000_0000_1000,
    S_GAIN   = 12'b0000_0001_0000,
    S_SCAN   = 12'b0000_0010_0000,
    S_COMMIT = 12'b0000_0100_0000,
    S_FR_RD  = 12'b0000_1000_0000,
    S_FR_MUL = 12'b0001_0000_0000,
    S_FR_DIV = 12'b0010_0000_0000,
    S_FR_ACC = 12'b0100_0000_0000,
    S_RESP   = 12'b1000_0000_0000
  } state_e;

  state_e state_q;
  cmd_t   cmd_q;

  logic [VOICES-1:0] act_q;
  logic [16:0] pos_q  [VOICES];
  logic [16:0] end_q  [VOICES];
  logic [15:0] frac_q [VOICES];
  logic [17:0] rate_q [VOICES];
  logic [6:0]  lg_q   [VOICES];
  logic [6:0]  rg_q   [VOICES];
  logic [7:0]  snd_q  [VOICES];
  logic [31:0] time_q [VOICES];
  logic [AW-1:0] idx_q [VOICES];

  logic [31:0] age_q;
  logic [15:0] nh_q;
  logic [15:0] red_q;
  logic [17:0] ss_q, dd_q;
  logic [24:0] pl_q, pr_q;
  logic [7:0]  gl_q, gr_q;
  logic [31:0] oldest_q;
  logic [VW-1:0] oslot_q, vi_q;
  logic signed [ACCW-1:0] accl_q, accr_q;
  logic [13:0] ml_q, mr_q;
  logic        neg_q;
  logic [8:0]  q1l_q, q1r_q;
  logic        status_q;
  logic [15:0] handle_q;
  logic [VW-1:0] slot_q;

  logic               ov_q;
  logic signed [15:0] ol_q, or_q;
  logic [15:0]        oh_q;
  logic [2:0]         os_q;
  logic               ost_q, oi_q;

  // ram
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  logic red_busy;
  assign red_busy = ({1'b0, red_q} >= DEPTH_A);
  assign ram_we   = (state_q == S_RED) && !red_busy && (cmd_q.op == OP_LOAD);
  assign ram_addr = (state_q == S_FR_RD) ? idx_q[vi_q] : AW'(red_q);

  mvm_ram #(.WIDTH(8), .DEPTH(SAMPLE_MEM_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(cmd_q.sample_byte),
    .rdata_o(ram_rdata)
  );

  // gain path operands
  logic [8:0] sep_s, sep_d;
  assign sep_s = {1'b0, cmd_q.separation} + 9'd1;
  assign sep_d = SEP_SPAN - sep_s;

  logic gain_bad;
  assign gain_bad = (gl_q > GAIN_MAX) || (gr_q > GAIN_MAX);

  // first active instance of the same sound
  logic [VOICES-1:0] excl_clr;
  always_comb begin
    logic hit;
    hit = 1'b0;
    excl_clr = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!hit && act_q[i] && (snd_q[i] == cmd_q.sound_id)) begin
        excl_clr[i] = 1'b1;
        hit = 1'b1;
      end
    end
  end

  logic          free_found;
  logic [VW-1:0] free_idx;
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = 0; i < VOICES; i++) begin
      if (!free_found && !act_q[i]) begin
        free_found = 1'b1;
        free_idx   = VW'(i);
      end
    end
  end

  logic [VW-1:0] new_slot;
  logic [15:0]   new_handle;
  assign new_slot   = free_found ? free_idx : oslot_q;
  assign new_handle = (nh_q == 16'd0) ? HANDLE_FIRST : nh_q;

  // sample magnitude
  logic       smp_neg;
  logic [7:0] smp_mag;
  assign smp_neg = !ram_rdata[7];
  assign smp_mag = smp_neg ? (8'd128 - ram_rdata) : (ram_rdata - 8'd128);

  // divide by 127: x*256/127 = 2x + floor(2x/127), reciprocal plus one fixup
  logic [14:0] xl, xr;
  logic [24:0] prl, prr;
  logic [16:0] rl, rr;
  logic [16:0] magl, magr;
  logic signed [ACCW-1:0] cl, cr;
  assign xl  = {ml_q, 1'b0};
  assign xr  = {mr_q, 1'b0};
  assign prl = 25'(xl * RECIP_127);
  assign prr = 25'(xr * RECIP_127);
  assign rl  = {2'b0, xl} - 17'(q1l_q * 8'd127);
  assign rr  = {2'b0, xr} - 17'(q1r_q * 8'd127);
  assign magl = {2'b0, xl} + {8'b0, q1l_q} + {16'b0, (rl >= DIV_127)};
  assign magr = {2'b0, xr} + {8'b0, q1r_q} + {16'b0, (rr >= DIV_127)};
  assign cl = neg_q ? -ACCW'(magl) : ACCW'(magl);
  assign cr = neg_q ? -ACCW'(magr) : ACCW'(magr);

  // voice advance
  logic [18:0] adv;
  logic [17:0] npos;
  logic        ended;
  logic [AW:0] isum;
  assign adv   = {3'b0, frac_q[vi_q]} + {1'b0, rate_q[vi_q]};
  assign npos  = {1'b0, pos_q[vi_q]} + {15'b0, adv[18:16]};
  assign ended = (npos >= {1'b0, end_q[vi_q]});
  assign isum  = {1'b0, idx_q[vi_q]} + (AW+1)'(adv[18:16]);

  function automatic logic signed [15:0] sat16(input logic signed [ACCW-1:0] v);
    if (v > $signed(ACCW'(SAT_MAX))) return SAT_MAX;
    if (v < -$signed(ACCW'(17'h08000))) return SAT_MIN;
    return v[15:0];
  endfunction

  logic out_free;
  assign out_free  = !ov_q || out_o.ready;
  assign cmd_pop_o = (state_q == S_IDLE) && cmd_valid_i;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_q <= cmd_i;
          red_q <= cmd_i.address;
        end
      end
      S_RED: begin
        if (red_busy) red_q <= red_q - DEPTH_A[15:0];
      end
      S_MUL1: begin
        ss_q <= 18'(sep_s * sep_s);
        dd_q <= 18'(sep_d * sep_d);
      end
      S_MUL2: begin
        pl_q <= 25'(cmd_q.volume * ss_q[16:0]);
        pr_q <= 25'(cmd_q.volume * dd_q[16:0]);
      end
      S_GAIN: begin
        gl_q <= 8'({1'b0, cmd_q.volume} - pl_q[24:16]);
        gr_q <= 8'({1'b0, cmd_q.volume} - pr_q[24:16]);
      end
      S_COMMIT: begin
        pos_q[new_slot]  <= {1'b0, cmd_q.address};
        end_q[new_slot]  <= {1'b0, cmd_q.address} + {1'b0, cmd_q.length};
        frac_q[new_slot] <= '0;
        rate_q[new_slot] <= cmd_q.step;
        time_q[new_slot] <= age_q;
        lg_q[new_slot]   <= gl_q[6:0];
        rg_q[new_slot]   <= gr_q[6:0];
        snd_q[new_slot]  <= cmd_q.sound_id;
        idx_q[new_slot]  <= AW'(red_q);
      end
      S_FR_MUL: begin
        ml_q  <= 14'(lg_q[vi_q] * smp_mag);
        mr_q  <= 14'(rg_q[vi_q] * smp_mag);
        neg_q <= smp_neg;
      end
      S_FR_DIV: begin
        q1l_q <= prl[24:16];
        q1r_q <= prr[24:16];
      end
      S_FR_ACC: begin
        frac_q[vi_q] <= adv[15:0];
        pos_q[vi_q]  <= npos[16:0];
        idx_q[vi_q]  <= (isum >= DEPTH_W) ? AW'(isum - DEPTH_W) : AW'(isum);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      act_q    <= '0;
      age_q    <= '0;
      nh_q     <= '0;
      vi_q     <= '0;
      oldest_q <= '0;
      oslot_q  <= '0;
      accl_q   <= '0;
      accr_q   <= '0;
      status_q <= 1'b0;
      handle_q <= '0;
      slot_q   <= '0;
      ov_q     <= 1'b0;
      ol_q     <= '0;
      or_q     <= '0;
      oh_q     <= '0;
      os_q     <= '0;
      ost_q    <= 1'b0;
      oi_q     <= 1'b0;
    end else begin
      if (ov_q && out_o.ready && (state_q != S_RESP)) ov_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            accl_q   <= '0;
            accr_q   <= '0;
            status_q <= 1'b0;
            handle_q <= '0;
            slot_q   <= '0;
            vi_q     <= '0;
            case (cmd_i.op)
              OP_LOAD, OP_START: state_q <= S_RED;
              OP_FRAME: state_q <= S_FR_RD;
              OP_TIME: begin
                age_q   <= age_q + 32'd1;
                state_q <= S_RESP;
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        S_RED: begin
          if (!red_busy) state_q <= (cmd_q.op == OP_LOAD) ? S_RESP : S_MUL1;
        end
        S_MUL1: state_q <= S_MUL2;
        S_MUL2: state_q <= S_GAIN;
        S_GAIN: state_q <= S_SCAN;
        S_SCAN: begin
          if (gain_bad) begin
            status_q <= 1'b1;
            state_q  <= S_RESP;
          end else if (handle_q == '0) begin
            // first scan cycle: drop an exclusive instance, seed the search
            if (cmd_q.exclusive) act_q <= act_q & ~excl_clr;
            oldest_q <= age_q;
            handle_q <= 16'hffff;
          end else begin
            if (time_q[vi_q] < oldest_q) begin
              oldest_q <= time_q[vi_q];
              oslot_q  <= vi_q;
            end
            if (vi_q == LAST_V) state_q <= S_COMMIT;
            else vi_q <= vi_q + VW'(1);
          end
        end
        S_COMMIT: begin
          act_q[new_slot] <= 1'b1;
          handle_q        <= new_handle;
          nh_q            <= new_handle + 16'd1;
          slot_q          <= new_slot;
          oslot_q         <= '0;
          state_q         <= S_RESP;
        end
        S_FR_RD: begin
          if (act_q[vi_q]) begin
            state_q <= S_FR_MUL;
          end else if (vi_q == LAST_V) begin
            state_q <= S_RESP;
          end else begin
            vi_q <= vi_q + VW'(1);
          end
        end
        S_FR_MUL: state_q <= S_FR_DIV;
        S_FR_DIV: state_q <= S_FR_ACC;
        S_FR_ACC: begin
          accl_q <= accl_q + cl;
          accr_q <= accr_q + cr;
          if (ended) act_q[vi_q] <= 1'b0;
          if (vi_q == LAST_V) begin
            state_q <= S_RESP;
          end else begin
            vi_q    <= vi_q + VW'(1);
            state_q <= S_FR_RD;
          end
        end
        S_RESP: begin
          if (out_free) begin
            ov_q    <= 1'b1;
            ol_q    <= sat16(accl_q);
            or_q    <= sat16(accr_q);
            oh_q    <= status_q ? 16'd0 : handle_q;
            os_q    <= 3'(slot_q);
            ost_q   <= status_q;
            oi_q    <= ~|act_q;
            oslot_q <= '0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.left_sample  = ol_q;
  assign out_o.right_sample = or_q;
  assign out_o.handle       = oh_q;
  assign out_o.voice        = os_q;
  assign out_o.status       = ost_q;
  assign out_o.all_idle     = oi_q;

endmodule

@@ hw/rtl/multi_voice_sample_mixer.sv @@
// Channel  Dir  Transaction
// in_i     in   one operation: load, start, frame or time
// out_o    out  one result per operation, in order
//
// Per operation, after it leaves the two-entry input queue:
//   load/start first reduce the address by SAMPLE_MEM_DEPTH while it is not below it;
//   start computes gains, then scans every voice (a rejected start skips the scan);
//   frame reads, scales and sums each active voice in turn (single sample memory port).
// Reset clears the voice active flags and control state; sample memory needs no clearing.
// A waiting result stalls only the back end; the queue keeps taking input until both entries are full.
`include "multi_voice_sample_mixer_macros.svh"

module multi_voice_sample_mixer import mvm_pkg::*; #(
  parameter int VOICES = 8,
  parameter int SAMPLE_MEM_DEPTH = 65536
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvm_in_if.sink    in_i,
  mvm_out_if.source out_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  mvm_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .cmd_o      (cmd),
    .cmd_valid_o(cmd_valid),
    .cmd_pop_i  (cmd_pop)
  );

  mvm_back #(.VOICES(VOICES), .SAMPLE_MEM_DEPTH(SAMPLE_MEM_DEPTH)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .out_o      (out_o)
  );

  `MVM_ASSERT(a_reject_hdl, out_o.valid && out_o.status |-> out_o.handle == '0, "rejected")
  `MVM_ASSERT(a_hdl_min, out_o.valid && out_o.handle != '0 |-> out_o.handle >= 16'd100, "low")
  `MVM_ASSERT(a_mix_hdl, out_o.valid && out_o.left_sample != '0 |-> out_o.handle == '0, "mix")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import mvm_pkg::*;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [15:0]        handle;
    logic [2:0]         voice;
    logic               status;
    logic               all_idle;
  } mix_result_t;

  typedef struct {
    op_e         op;
    logic [15:0] address;
    logic [7:0]  sample_byte;
    logic [7:0]  sound_id;
    logic [15:0] length;
    logic        exclusive;
    logic [17:0] step;
    logic [7:0]  volume;
    logic [7:0]  separation;
    logic        has_known;
    mix_result_t known;
  } stim_row_t;

  localparam int NVOICE = 8;
  localparam int WAVE_BASE = 16'h1000;
  localparam int WAVE_SPAN = 128;

  logic clk_i;
  logic rst_ni;

  mvm_in_if  in_ch ();
  mvm_out_if out_ch ();

  multi_voice_sample_mixer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // predictor state
  logic [7:0]  mem_bytes [int];
  logic        vc_on    [NVOICE];
  logic [31:0] vc_pos   [NVOICE];
  logic [31:0] vc_end   [NVOICE];
  logic [31:0] vc_frac  [NVOICE];
  logic [31:0] vc_rate  [NVOICE];
  logic [31:0] vc_lg    [NVOICE];
  logic [31:0] vc_rg    [NVOICE];
  logic [7:0]  vc_snd   [NVOICE];
  logic [31:0] vc_born  [NVOICE];
  logic [31:0] age_now;
  logic [15:0] handle_next;

  mix_result_t pending_mix [$];
  logic        known_flag  [$];
  mix_result_t known_mix   [$];
  int          error_count;
  int          seen_count;
  int          frames_seen;
  int          starts_seen;
  int          rejects_seen;
  int          max_voices_seen;
  bit          stall_on;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #(12ns * 2000000);
    $display("tb_top: timeout");
    $display("tb_top: done, errors");
    $finish;
  end

  function automatic int signed gain_scale(logic [31:0] gain, logic [7:0] smp);
    int signed v;
    v = int'(gain & 127) * (int'(smp) - 128) * 256;
    return v / 127;
  endfunction

  function automatic logic signed [15:0] clip16(int signed v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return -16'sh8000;
    return v[15:0];
  endfunction

  function automatic void gains_for(logic [7:0] vol, logic [7:0] sep,
                                    output logic [31:0] lg, output logic [31:0] rg);
    logic [31:0] s;
    logic [31:0] d;
    s = 32'(sep) + 1;
    d = 257 - s;
    lg = 32'(vol) - (32'(vol) * s * s) / 65536;
    rg = 32'(vol) - (32'(vol) * d * d) / 65536;
  endfunction

  function automatic mix_result_t mix_apply(stim_row_t c);
    mix_result_t r;
    logic [31:0] lg, rg, oldest, acc, pos;
    int signed   dl, dr;
    int          i, slot, oldest_slot, n;
    logic [7:0]  smp;
    r = '{default: '0};
    case (c.op)
      OP_LOAD: mem_bytes[c.address] = c.sample_byte;
      OP_START: begin
        gains_for(c.volume, c.separation, lg, rg);
        if (lg > 127 || rg > 127) begin
          r.status = 1'b1;
        end else begin
          oldest = age_now;
          oldest_slot = 0;
          if (c.exclusive) begin
            for (i = 0; i < NVOICE; i++) begin
              if (vc_on[i] && vc_snd[i] == c.sound_id) begin
                vc_on[i] = 1'b0;
                break;
              end
            end
          end
          for (i = 0; i < NVOICE && vc_on[i]; i++) begin
            if (vc_born[i] < oldest) begin
              oldest_slot = i;
              oldest = vc_born[i];
            end
          end
          slot = (i == NVOICE) ? oldest_slot : i;
          if (handle_next == 16'd0) handle_next = HANDLE_FIRST;
          r.handle = handle_next;
          handle_next = handle_next + 16'd1;
          vc_on[slot] = 1'b1;
          vc_pos[slot] = 32'(c.address);
          vc_end[slot] = 32'(c.address) + 32'(c.length);
          vc_frac[slot] = 0;
          vc_rate[slot] = 32'(c.step);
          vc_born[slot] = age_now;
          vc_lg[slot] = lg;
          vc_rg[slot] = rg;
          vc_snd[slot] = c.sound_id;
          r.voice = slot[2:0];
          starts_seen++;
        end
        if (r.status) rejects_seen++;
      end
      OP_FRAME: begin
        dl = 0;
        dr = 0;
        for (i = 0; i < NVOICE; i++) begin
          if (vc_on[i]) begin
            smp = mem_bytes.exists(vc_pos[i] % 65536) ? mem_bytes[vc_pos[i] % 65536] : 8'd0;
            dl += gain_scale(vc_lg[i], smp);
            dr += gain_scale(vc_rg[i], smp);
            acc = vc_frac[i] + vc_rate[i];
            pos = vc_pos[i] + (acc >> 16);
            vc_frac[i] = acc & 32'hffff;
            if (pos >= vc_end[i]) begin
              vc_on[i] = 1'b0;
              pos &= 32'h1ffff;
            end
            vc_pos[i] = pos;
          end
        end
        r.left = clip16(dl);
        r.right = clip16(dr);
        frames_seen++;
      end
      default: age_now = age_now + 32'd1;
    endcase
    n = 0;
    for (i = 0; i < NVOICE; i++) n += vc_on[i];
    if (n > max_voices_seen) max_voices_seen = n;
    r.all_idle = (n == 0);
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("tb_top: mismatch #%0d on %s: got %0d, want %0d", seen_count, what, got, want);
    error_count++;
  endtask

  // receiver with its own stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    mix_result_t w;
    mix_result_t k;
    logic        kf;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_mix.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        w = pending_mix.pop_front();
        kf = known_flag.pop_front();
        k = known_mix.pop_front();
        if (out_ch.left_sample !== w.left)
          report_mismatch("left", out_ch.left_sample, w.left);
        if (out_ch.right_sample !== w.right)
          report_mismatch("right", out_ch.right_sample, w.right);
        if (out_ch.handle !== w.handle) report_mismatch("handle", out_ch.handle, w.handle);
        if (out_ch.voice !== w.voice) report_mismatch("voice", out_ch.voice, w.voice);
        if (out_ch.status !== w.status) report_mismatch("status", out_ch.status, w.status);
        if (out_ch.all_idle !== w.all_idle)
          report_mismatch("all_idle", out_ch.all_idle, w.all_idle);
        if (kf && (k.left !== w.left || k.right !== w.right || k.handle !== w.handle ||
                   k.voice !== w.voice || k.status !== w.status || k.all_idle !== w.all_idle))
          report_mismatch("typed-in row", 0, 1);
      end
      seen_count++;
    end
  end

  task automatic send(stim_row_t c);
    mix_result_t r;
    in_ch.valid       <= 1'b1;
    in_ch.operation   <= c.op;
    in_ch.address     <= c.address;
    in_ch.sample_byte <= c.sample_byte;
    in_ch.sound_id    <= c.sound_id;
    in_ch.length      <= c.length;
    in_ch.exclusive   <= c.exclusive;
    in_ch.step        <= c.step;
    in_ch.volume      <= c.volume;
    in_ch.separation  <= c.separation;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    r = mix_apply(c);
    pending_mix.push_back(r);
    known_flag.push_back(c.has_known);
    known_mix.push_back(c.known);
  endtask

  task automatic gap();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // sender in bursts; gap decided between bursts
  int burst_left;
  task automatic drive(stim_row_t c);
    int g;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      g = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      repeat (g) gap();
    end
    burst_left--;
    send(c);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_mix.size() != 0) @(posedge clk_i);
  endtask

  function automatic stim_row_t blank(op_e op);
    stim_row_t c;
    c = '{op: op, default: '0};
    c.known = '{default: '0};
    c.address = 16'($urandom());
    c.sample_byte = 8'($urandom());
    c.sound_id = 8'($urandom());
    c.length = 16'($urandom());
    c.exclusive = 1'($urandom());
    c.step = 18'($urandom());
    c.volume = 8'($urandom());
    c.separation = 8'($urandom());
    return c;
  endfunction

  function automatic stim_row_t mk_load(logic [15:0] a, logic [7:0] b);
    stim_row_t c;
    c = blank(OP_LOAD);
    c.address = a;
    c.sample_byte = b;
    return c;
  endfunction

  function automatic stim_row_t mk_start(logic [15:0] a, logic [15:0] len, logic [17:0] st,
                                         logic [7:0] vol, logic [7:0] sep, logic [7:0] snd,
                                         logic ex);
    stim_row_t c;
    c = blank(OP_START);
    c.address = a;
    c.length = len;
    c.step = st;
    c.volume = vol;
    c.separation = sep;
    c.sound_id = snd;
    c.exclusive = ex;
    return c;
  endfunction

  // keep any voice inside written memory: read pos stays <= end < WAVE_BASE+WAVE_SPAN
  function automatic stim_row_t rand_start();
    logic [15:0] a, len;
    logic [7:0]  vol;
    a = 16'(WAVE_BASE + $urandom_range(0, WAVE_SPAN - 1));
    len = 16'($urandom_range(0, WAVE_BASE + WAVE_SPAN - 1 - a));
    vol = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 127));
    return mk_start(a, len, ($urandom_range(0, 9) == 0) ? 18'($urandom) :
                    18'($urandom_range(0, 32'h30000)),
                    vol, 8'($urandom), 8'($urandom_range(0, 5)), 1'($urandom));
  endfunction

  stim_row_t dir_rows [$];

  initial begin
    stim_row_t c;
    int i;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_TIME;
    in_ch.address = '0;
    in_ch.sample_byte = '0;
    in_ch.sound_id = '0;
    in_ch.length = '0;
    in_ch.exclusive = 1'b0;
    in_ch.step = '0;
    in_ch.volume = '0;
    in_ch.separation = '0;
    stall_on = 1'b0;
    burst_left = 0;
    error_count = 0;
    seen_count = 0;
    frames_seen = 0;
    starts_seen = 0;
    rejects_seen = 0;
    max_voices_seen = 0;
    age_now = '0;
    handle_next = '0;
    for (i = 0; i < NVOICE; i++) begin
      vc_on[i] = 1'b0; vc_pos[i] = '0; vc_end[i] = '0; vc_frac[i] = '0; vc_rate[i] = '0;
      vc_lg[i] = '0; vc_rg[i] = '0; vc_snd[i] = '0; vc_born[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    c = blank(OP_FRAME); c.has_known = 1'b1; c.known.all_idle = 1'b1; dir_rows.push_back(c);
    c = blank(OP_TIME); c.has_known = 1'b1; c.known.all_idle = 1'b1; dir_rows.push_back(c);
    c = mk_load(16'h0000, 8'h00); dir_rows.push_back(c);
    c = mk_load(16'hffff, 8'hff); dir_rows.push_back(c);
    c = mk_load(16'h0001, 8'd128); dir_rows.push_back(c);
    // full volume at the center is rejected
    c = mk_start(16'h0000, 16'd0, 18'd0, 8'hff, 8'd128, 8'd1, 1'b0);
    c.has_known = 1'b1; c.known.status = 1'b1; c.known.all_idle = 1'b1; dir_rows.push_back(c);
    // first handle is 100, slot 0; zero length plays one sample
    c = mk_start(16'hffff, 16'd0, 18'h3ffff, 8'd127, 8'd255, 8'd255, 1'b1);
    c.has_known = 1'b1; c.known.handle = 16'd100; dir_rows.push_back(c);
    c = blank(OP_FRAME); dir_rows.push_back(c);
    // zero step repeats its sample
    c = mk_start(16'h0000, 16'hffff, 18'd0, 8'd127, 8'd0, 8'd7, 1'b0); dir_rows.push_back(c);
    c = mk_start(16'h0000, 16'd1, 18'h10000, 8'd90, 8'd128, 8'd7, 1'b1); dir_rows.push_back(c);
    c = blank(OP_FRAME); dir_rows.push_back(c);
    c = blank(OP_FRAME); dir_rows.push_back(c);
    c = blank(OP_TIME); dir_rows.push_back(c);
    for (i = 0; i < 9; i++) begin
      // fill every slot, then replace the oldest
      c = mk_start(16'hffff, 16'h0001, 18'h08000, 8'd127, 8'($urandom_range(0, 255)),
                   8'(20 + i), 1'b0);
      dir_rows.push_back(c);
    end
    c = blank(OP_FRAME); dir_rows.push_back(c);
    c = blank(OP_FRAME); dir_rows.push_back(c);
    foreach (dir_rows[j]) drive(dir_rows[j]);
    drain();
    repeat (3) gap();

    // a bank of waveform bytes for random voices
    for (i = 0; i < WAVE_SPAN; i++) drive(mk_load(16'(WAVE_BASE + i), 8'($urandom)));
    drain();

    stall_on = 1'b1;
    for (i = 0; i < 300; i++) begin
      case ($urandom_range(0, 9))
        0: drive(mk_load(16'(WAVE_BASE + $urandom_range(0, WAVE_SPAN - 1)), 8'($urandom)));
        1, 2, 3: drive(rand_start());
        4: drive(blank(OP_TIME));
        default: drive(blank(OP_FRAME));
      endcase
      if (i == 150) drain();
    end
    drain();
    repeat (100) @(posedge clk_i);

    $display("tb_top: %0d results checked, %0d frames, %0d starts, %0d rejected",
             seen_count, frames_seen, starts_seen, rejects_seen);
    $display("tb_top: up to %0d voices sounding at once", max_voices_seen);
    if (error_count == 0 && pending_mix.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
